// ===== rtl/rdr_pkg.sv =====
// Package for the reliable datagram receiver: transfer payload types and fixed constants.
// No dependencies; every rtl file refers to it by scoped names.
`default_nettype none

package rdr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned CSUM_W  = 16;

    // Hard ceiling on the accepted packet length, whatever the register holds.
    localparam logic [LEN_W:0]    MAX_PACKET_BYTES = 13'd2048;
    localparam logic [LEN_W-1:0]  MAX_BYTES_RESET  = 12'd1500;
    localparam logic [LEN_W-1:0]  HEADER_BYTES     = 12'd8;
    // Byte position of the low checksum byte; the pair 4..5 is never summed.
    localparam logic [LEN_W-1:0]  CSUM_LOW_POS     = 12'd5;
    localparam logic [CSUM_W-1:0] ALL_ONES         = 16'hFFFF;
    localparam logic [CSUM_W-1:0] ACK_TYPE         = 16'hAAAA;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0]  ack_number;
        logic              in_order;
        logic [CSUM_W-1:0] ack_checksum;
    } t_out_item;

    // Acknowledgement decision passed from the parser to the checksum stage.
    typedef struct packed {
        logic [SEQ_W-1:0] ack_number;
        logic             in_order;
    } t_ack;

endpackage

`default_nettype wire

// ===== rtl/rdr_parse.sv =====
// Packet parser: byte position, header capture, running word sum and expected sequence.
// Depends on rdr_pkg. Consumes one byte per enabled cycle and flags a passing packet end.
`default_nettype none

module rdr_parse (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire rdr_pkg::t_in_item           i_item,
    input  wire logic [rdr_pkg::LEN_W-1:0]   i_max_bytes,
    output logic                             o_ack_valid,
    output rdr_pkg::t_ack                    o_ack
);

    logic [rdr_pkg::LEN_W-1:0]  r_pos,  n_pos;
    logic [rdr_pkg::CSUM_W-1:0] r_sum,  n_sum;
    logic [rdr_pkg::BYTE_W-1:0] r_pend, n_pend;
    logic [rdr_pkg::SEQ_W-1:0]  r_hseq, n_hseq;
    logic [rdr_pkg::CSUM_W-1:0] r_hck,  n_hck;
    logic [rdr_pkg::SEQ_W-1:0]  r_exp,  n_exp;

    logic [rdr_pkg::LEN_W-1:0]  limit;
    logic                       take;
    logic [rdr_pkg::CSUM_W-1:0] fin_sum;
    logic                       pass;
    logic                       match;
    logic [rdr_pkg::SEQ_W-1:0]  exp_inc;

    always_comb begin
        if ({1'b0, i_max_bytes} > rdr_pkg::MAX_PACKET_BYTES) begin
            limit = rdr_pkg::MAX_PACKET_BYTES[rdr_pkg::LEN_W-1:0];
        end else begin
            limit = i_max_bytes;
        end
        take = (r_pos < limit);

        n_pos  = r_pos;
        n_sum  = r_sum;
        n_pend = r_pend;
        n_hseq = r_hseq;
        n_hck  = r_hck;
        if (take) begin
            if (r_pos < 12'd4) begin
                n_hseq = {r_hseq[rdr_pkg::SEQ_W-rdr_pkg::BYTE_W-1:0], i_item.data_byte};
            end else if (r_pos < 12'd6) begin
                n_hck = {r_hck[rdr_pkg::CSUM_W-rdr_pkg::BYTE_W-1:0], i_item.data_byte};
            end
            if (!r_pos[0]) begin
                n_pend = i_item.data_byte;
            end else if (r_pos != rdr_pkg::CSUM_LOW_POS) begin
                n_sum = r_sum + {i_item.data_byte, r_pend};
            end
            n_pos = r_pos + 12'd1;
        end

        // Odd length: add the last low byte with a zero pad.
        if (n_pos[0] && (n_pos != rdr_pkg::CSUM_LOW_POS)) begin
            fin_sum = n_sum + {8'd0, n_pend};
        end else begin
            fin_sum = n_sum;
        end
        pass    = (n_pos >= rdr_pkg::HEADER_BYTES) &&
                  ((n_hck ^ fin_sum) == rdr_pkg::ALL_ONES);
        match   = (n_hseq == r_exp);
        exp_inc = r_exp + 32'd1;

        n_exp = r_exp;
        if (i_fire && i_item.last_byte && pass && match) begin
            n_exp = exp_inc;
        end

        o_ack_valid     = i_fire && i_item.last_byte && pass;
        o_ack.ack_number = match ? exp_inc : r_exp;
        o_ack.in_order   = match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_pend <= '0;
            r_hseq <= '0;
            r_hck  <= '0;
            r_exp  <= '0;
        end else if (i_fire) begin
            r_exp <= n_exp;
            // Packet end: drop all per-packet state.
            if (i_item.last_byte) begin
                r_pos  <= '0;
                r_sum  <= '0;
                r_pend <= '0;
                r_hseq <= '0;
                r_hck  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_sum  <= n_sum;
                r_pend <= n_pend;
                r_hseq <= n_hseq;
                r_hck  <= n_hck;
            end
        end
    end

    a_exp_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_item.last_byte) |=> $stable(r_exp))
        else $error("expected sequence moved outside a packet end");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} <= rdr_pkg::MAX_PACKET_BYTES)
        else $error("byte position ran past the packet ceiling");

endmodule

`default_nettype wire

// ===== rtl/reliable_datagram_receiver_core.sv =====
// Top level of the reliable datagram receiver: input register, parser, ack checksum stage.
// Depends on rdr_pkg and rdr_parse.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (rdr_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (rdr_pkg::t_out_item)
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_wdata (max_packet_bytes)
//
// One byte per cycle while the output is not stalled; the last byte passes the input
// register, then the decision register and the output register, which offers the result.
// Synchronous active-low reset clears control, parser state and sets the limit to 1500.
// An output stall backs up one stage at a time; the input keeps taking bytes until
// the input, decision and output registers are all full.
`default_nettype none

module reliable_datagram_receiver_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire rdr_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rdr_pkg::t_out_item              o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [rdr_pkg::LEN_W-1:0]  i_cfg_wdata
);

    logic [rdr_pkg::LEN_W-1:0] r_max_bytes;

    logic                  r_a_valid;
    rdr_pkg::t_in_item     r_a_data;
    logic                  r_b_valid;
    rdr_pkg::t_ack         r_b_data;
    logic                  r_c_valid;
    rdr_pkg::t_out_item    r_c_data;

    logic                  c_ready;
    logic                  b_ready;
    logic                  a_fire;
    logic                  in_fire;
    logic                  ack_valid;
    rdr_pkg::t_ack         ack;
    logic [rdr_pkg::CSUM_W-1:0] ack_sum;

    assign c_ready    = !r_c_valid || i_out_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_fire     = r_a_valid && b_ready;
    assign o_in_ready = !r_a_valid || b_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    rdr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (a_fire),
        .i_item      (r_a_data),
        .i_max_bytes (r_max_bytes),
        .o_ack_valid (ack_valid),
        .o_ack       (ack)
    );

    // Little-endian word sum of the ack header: big-endian sequence bytes, then the type.
    assign ack_sum = ~({r_b_data.ack_number[23:16], r_b_data.ack_number[31:24]}
                     + {r_b_data.ack_number[7:0],   r_b_data.ack_number[15:8]}
                     + rdr_pkg::ACK_TYPE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= rdr_pkg::MAX_BYTES_RESET;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= ack_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_data <= i_in_data;
        end
        if (b_ready && ack_valid) begin
            r_b_data <= ack;
        end
        if (c_ready && r_b_valid) begin
            r_c_data.ack_number   <= r_b_data.ack_number;
            r_c_data.in_order     <= r_b_data.in_order;
            r_c_data.ack_checksum <= ack_sum;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c_data;

    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !c_ready) |=> (r_b_valid && $stable(r_b_data)))
        else $error("decision register changed while blocked");

    a_a_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_a_valid) |-> a_fire)
        else $error("input register overwritten before the parser took it");

    a_ack_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ack_valid |-> (a_fire && r_a_data.last_byte))
        else $error("acknowledgement raised without a consumed last byte");

    a_c_from_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_c_valid) |-> $past(r_b_valid))
        else $error("output became valid with no decision behind it");

endmodule

`default_nettype wire
